// File: rtl/gidm_pkg.sv
// Shared types and constants for the group identifier membership table.
package gidm_pkg;

    // Identifier, list limit and reported count widths
    localparam int ID_W        = 48;
    localparam int LIMIT_W     = 5;
    localparam int COUNT_OUT_W = 5;
    localparam int MAX_OUT     = 16;
    localparam int QUEUE_DEPTH = 2;

    // Command codes
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_LIST   = 2'd3
    } cmd_t;

    // Status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Input transfer payload
    typedef struct packed {
        cmd_t               cmd;
        logic [ID_W-1:0]    gid;
        logic [LIMIT_W-1:0] max_entries;
    } cmd_item_t;

    // Result transfer payload
    typedef struct packed {
        logic                   status;
        logic                   is_member;
        logic [COUNT_OUT_W-1:0] group_count;
        logic [ID_W-1:0]        entry_id;
        logic                   entry_valid;
        logic                   last;
    } rsp_item_t;

    // Classified command as queued between front and back
    typedef struct packed {
        cmd_t               cmd;
        logic [ID_W-1:0]    gid;
        logic [LIMIT_W-1:0] limit;
    } op_t;

endpackage

// File: rtl/gidm_front.sv
// Front end: accepts command transfers, classifies them and hands them to the queue.
module gidm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  gidm_pkg::cmd_item_t cmd_data,
    output logic              op_valid,
    input  logic              op_ready,
    output gidm_pkg::op_t     op
);

    logic          hold_valid_reg;
    logic          hold_valid_next;
    gidm_pkg::op_t op_reg;
    gidm_pkg::op_t op_next;
    logic          accept;
    logic          push;

    // Stall only while the held command cannot move on
    assign push      = hold_valid_reg && op_ready;
    assign cmd_stall = hold_valid_reg && !op_ready;
    assign accept    = cmd_valid && !cmd_stall;

    // Classify: clamp the list limit to the most results one command may give
    always_comb
    begin
        op_next.cmd = cmd_data.cmd;
        op_next.gid = cmd_data.gid;
        if (cmd_data.max_entries > gidm_pkg::LIMIT_W'(gidm_pkg::MAX_OUT))
        begin
            op_next.limit = gidm_pkg::LIMIT_W'(gidm_pkg::MAX_OUT);
        end
        else
        begin
            op_next.limit = cmd_data.max_entries;
        end
    end

    assign hold_valid_next = accept || (hold_valid_reg && !push);

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Capture the classified command on each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

    assign op_valid = hold_valid_reg;
    assign op       = op_reg;

endmodule

// File: rtl/gidm_queue.sv
// Short command queue between the front end and the table engine.
module gidm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gidm_pkg::op_t push_data,
    output logic          ready,
    input  logic          pop,
    output logic          valid,
    output gidm_pkg::op_t head
);

    localparam int PTR_W  = $clog2(gidm_pkg::QUEUE_DEPTH);
    localparam int FILL_W = $clog2(gidm_pkg::QUEUE_DEPTH + 1);

    gidm_pkg::op_t    slot_reg [gidm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign ready   = fill_reg != FILL_W'(gidm_pkg::QUEUE_DEPTH);
    assign valid   = fill_reg != FILL_W'(0);
    assign do_push = push && ready;
    assign do_pop  = pop && valid;
    assign head    = slot_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/gidm_back.sv
// Table engine: holds the identifier set, executes commands and drives results.
module gidm_back #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  gidm_pkg::op_t       q_head,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output gidm_pkg::rsp_item_t rsp_data
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CMP_W = (CNT_W > gidm_pkg::LIMIT_W) ? CNT_W : gidm_pkg::LIMIT_W;

    typedef enum logic [3:0] {
        S_FETCH = 4'b0001,
        S_CMP   = 4'b0010,
        S_EXEC  = 4'b0100,
        S_LIST  = 4'b1000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    gidm_pkg::op_t         op_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [gidm_pkg::ID_W-1:0] ids_reg  [TABLE_ENTRIES];
    logic [gidm_pkg::ID_W-1:0] ids_next [TABLE_ENTRIES];
    logic                  found_reg;
    logic [TABLE_ENTRIES-1:0] ge_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      n_next;
    logic [CNT_W-1:0]      idx_reg;
    logic                  rsp_valid_reg;
    gidm_pkg::rsp_item_t   rsp_reg;
    gidm_pkg::rsp_item_t   rsp_next;

    logic [TABLE_ENTRIES-1:0] hit;
    logic [TABLE_ENTRIES-1:0] ge;
    logic                  out_free;
    logic                  exec_go;
    logic                  list_step;
    logic                  list_last;
    logic                  full;
    logic                  count_zero;
    logic                  do_insert;
    logic                  do_remove;
    logic                  list_more;
    logic                  emit;
    logic                  finish;
    logic                  member_after;
    logic [CMP_W-1:0]      lim_w;
    logic [CMP_W-1:0]      cnt_w;

    function automatic logic [gidm_pkg::COUNT_OUT_W-1:0] count_out(input logic [CNT_W-1:0] c);
        return gidm_pkg::COUNT_OUT_W'(c);
    endfunction

    // Compare every stored entry against the command identifier
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_match
        assign hit[i] = (ids_reg[i] == op_reg.gid) && (CNT_W'(i) < count_reg);
        assign ge[i]  = |hit[i:0];
    end

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign full       = count_reg == CNT_W'(TABLE_ENTRIES);
    assign count_zero = count_reg == CNT_W'(0);
    assign do_insert  = (op_reg.cmd == gidm_pkg::CMD_ADD) && !found_reg && !full;
    assign do_remove  = (op_reg.cmd == gidm_pkg::CMD_DELETE) && found_reg;

    // Entries to list: smallest of the clamped limit and the stored count
    assign lim_w  = CMP_W'(op_reg.limit);
    assign cnt_w  = CMP_W'(count_reg);
    assign n_next = (lim_w < cnt_w) ? CNT_W'(lim_w) : count_reg;

    assign exec_go   = (state_reg == S_EXEC) && out_free;
    assign list_more = (op_reg.cmd == gidm_pkg::CMD_LIST) && (n_next != CNT_W'(0));
    assign list_step = (state_reg == S_LIST) && out_free;
    assign list_last = idx_reg == (n_reg - CNT_W'(1));
    assign emit      = (exec_go && !list_more) || list_step;
    assign finish    = (exec_go && !list_more) || (list_step && list_last);
    assign q_pop     = q_valid && ((state_reg == S_FETCH) || finish);

    // Sequence compare, execute and readout
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_FETCH:
            begin
                if (q_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    if (list_more)
                    begin
                        state_next = S_LIST;
                    end
                    else
                    begin
                        state_next = q_valid ? S_CMP : S_FETCH;
                    end
                end
            end
            S_LIST:
            begin
                if (out_free && list_last)
                begin
                    state_next = q_valid ? S_CMP : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_FETCH;
            end
        endcase
    end

    // Update the stored count
    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Membership after the command
    always_comb
    begin
        unique case (op_reg.cmd)
            gidm_pkg::CMD_ADD:    member_after = found_reg || !full;
            gidm_pkg::CMD_DELETE: member_after = 1'b0;
            gidm_pkg::CMD_QUERY:  member_after = found_reg;
            gidm_pkg::CMD_LIST:   member_after = found_reg;
            default:              member_after = found_reg;
        endcase
    end

    // Build the next result
    always_comb
    begin
        rsp_next.status      = gidm_pkg::STATUS_DONE;
        rsp_next.is_member   = member_after;
        rsp_next.group_count = count_out(count_next);
        rsp_next.entry_id    = '0;
        rsp_next.entry_valid = 1'b0;
        rsp_next.last        = 1'b1;
        if (state_reg == S_LIST)
        begin
            rsp_next.group_count = count_out(count_reg);
            rsp_next.entry_id    = ids_reg[idx_reg[IDX_W-1:0]];
            rsp_next.entry_valid = 1'b1;
            rsp_next.last        = list_last;
        end
        else if ((op_reg.cmd == gidm_pkg::CMD_ADD) && !found_reg && full)
        begin
            rsp_next.status = gidm_pkg::STATUS_FULL;
        end
    end

    // Per-entry next value: insert behind the head, or close the gap on delete
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        logic [gidm_pkg::ID_W-1:0] up_val;
        logic [gidm_pkg::ID_W-1:0] down_val;
        logic                      take_id;

        if (i < TABLE_ENTRIES - 1)
        begin : g_up
            assign up_val = ids_reg[i+1];
        end
        else
        begin : g_top
            assign up_val = ids_reg[i];
        end

        if (i == 0)
        begin : g_head
            assign take_id  = count_zero;
            assign down_val = ids_reg[i];
        end
        else if (i == 1)
        begin : g_second
            assign take_id  = !count_zero;
            assign down_val = ids_reg[i];
        end
        else
        begin : g_rest
            assign take_id  = 1'b0;
            assign down_val = ids_reg[i-1];
        end

        always_comb
        begin
            ids_next[i] = ids_reg[i];
            if (do_insert)
            begin
                ids_next[i] = take_id ? op_reg.gid : down_val;
            end
            else if (do_remove && ge_reg[i])
            begin
                ids_next[i] = up_val;
            end
        end

        always_ff @(posedge clk)
        begin
            if (exec_go)
            begin
                ids_reg[i] <= ids_next[i];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FETCH;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                count_reg <= count_next;
            end
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Command, match and readout registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_head;
        end
        if (state_reg == S_CMP)
        begin
            found_reg <= |hit;
            ge_reg    <= ge;
        end
        if (exec_go)
        begin
            n_reg   <= n_next;
            idx_reg <= '0;
        end
        else if (list_step)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("stored count above table size");

    a_unique_ids: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> $onehot0(hit))
        else $error("identifier stored more than once");

    a_list_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (n_reg != CNT_W'(0)) && (idx_reg < n_reg))
        else $error("readout index out of range");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && do_remove) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not shrink the set");
`endif

endmodule

// File: rtl/group_id_membership_table_top.sv
// A command's first result is registered behind the front-end register, the queue,
// the engine's command register and the compare register. In the table engine, add,
// delete and query each compare over all entries, then update; a list readout follows.
// The front end and a 2-entry queue take new commands while the engine works.
// Reset clears control state and the stored count; identifier storage is not
// cleared and needs no clearing pass.
module group_id_membership_table_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  gidm_pkg::cmd_item_t cmd_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output gidm_pkg::rsp_item_t rsp_data
);

    logic          op_valid;
    logic          op_ready;
    gidm_pkg::op_t op;
    logic          q_valid;
    logic          q_pop;
    gidm_pkg::op_t q_head;

    gidm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op)
    );

    gidm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_valid),
        .push_data (op),
        .ready     (op_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    gidm_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
